// ----- rtl/r2q_pkg.sv -----
// Shared types, constants and step functions for the rotation-to-quaternion pipeline.
// No dependencies.
package r2q_pkg;

    localparam int IN_W      = 168;   // nine 18-bit fields, padded to bytes
    localparam int OUT_W     = 72;    // four 18-bit fields
    localparam int FW        = 18;
    localparam int ONE_Q16   = 65536;
    localparam int SQ_STAGES = 9;     // two root bits per stage
    localparam int DV_STAGES = 8;     // three quotient bits per stage
    localparam int RECIP_REM = 128;   // 2^31 >> 24, below any root

    localparam logic [1:0] SEL_X     = 2'd0;
    localparam logic [1:0] SEL_Y     = 2'd1;
    localparam logic [1:0] SEL_Z     = 2'd2;
    localparam logic [1:0] SEL_TRACE = 2'd3;

    // branch select plus the three sums/differences, ordered w,x,y,z
    // with the half-root component left out
    typedef struct packed {
        logic [1:0]         sel;
        logic signed [18:0] da;
        logic signed [18:0] db;
        logic signed [18:0] dc;
    } side_t;

    typedef struct packed {
        logic [20:0] rem;
        logic [17:0] root;
    } sq_t;

    typedef struct packed {
        logic [17:0] rem;
        logic [23:0] quo;
    } dv_t;

    function automatic sq_t sqrt_step(sq_t a, logic [1:0] pair);
        logic [20:0] cur;
        logic [20:0] trial;
        sq_t         o;
        cur   = {a.rem[18:0], pair};
        trial = {1'b0, a.root, 2'b01};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {a.root[16:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {a.root[16:0], 1'b0};
        end
        return o;
    endfunction

    function automatic dv_t div_step(dv_t a, logic [17:0] den);
        logic [18:0] cur;
        logic [18:0] diff;
        dv_t         o;
        cur  = {a.rem, 1'b0};
        diff = cur - {1'b0, den};
        if (cur >= {1'b0, den}) begin
            o.rem = diff[17:0];
            o.quo = {a.quo[22:0], 1'b1};
        end else begin
            o.rem = cur[17:0];
            o.quo = {a.quo[22:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [17:0] sat18(logic signed [28:0] v);
        logic [17:0] o;
        if (v > 29'sd131071)
            o = 18'h1FFFF;
        else if (v < -29'sd131072)
            o = 18'h20000;
        else
            o = v[17:0];
        return o;
    endfunction

endpackage

// ----- rtl/r2q_prep.sv -----
// Entry stage: trace, branch choice, clamped radicand and the element sums.
// Uses r2q_pkg.
module r2q_prep
    import r2q_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [IN_W-1:0]  in_data,
    output logic             valid_reg,
    output logic [18:0]      rad_reg,
    output side_t            side_reg
);

    logic signed [17:0] m [9];
    logic signed [19:0] t;
    logic signed [20:0] rad_full;
    logic signed [18:0] d_a, d_b, d_c, s_xy, s_xz, s_yz;
    logic [18:0]        rad_next;
    side_t              side_next;

    always_comb begin
        for (int i = 0; i < 9; i++)
            m[i] = $signed(in_data[FW*i +: FW]);
        t    = 20'(m[0]) + 20'(m[4]) + 20'(m[8]);
        d_a  = 19'(m[7]) - 19'(m[5]);
        d_b  = 19'(m[2]) - 19'(m[6]);
        d_c  = 19'(m[3]) - 19'(m[1]);
        s_xy = 19'(m[1]) + 19'(m[3]);
        s_xz = 19'(m[6]) + 19'(m[2]);
        s_yz = 19'(m[5]) + 19'(m[7]);
        if (t > 20'sd0) begin
            side_next = '{sel: SEL_TRACE, da: d_a, db: d_b, dc: d_c};
            rad_full  = 21'(ONE_Q16) + 21'(t);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            side_next = '{sel: SEL_X, da: d_a, db: s_xy, dc: s_xz};
            rad_full  = 21'(ONE_Q16) + 21'(m[0]) - 21'(m[4]) - 21'(m[8]);
        end else if (m[4] > m[8]) begin
            side_next = '{sel: SEL_Y, da: d_b, db: s_xy, dc: s_yz};
            rad_full  = 21'(ONE_Q16) + 21'(m[4]) - 21'(m[0]) - 21'(m[8]);
        end else begin
            side_next = '{sel: SEL_Z, da: d_c, db: s_xz, dc: s_yz};
            rad_full  = 21'(ONE_Q16) + 21'(m[8]) - 21'(m[0]) - 21'(m[4]);
        end
        rad_next = (rad_full < 21'sd1) ? 19'd1 : rad_full[18:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

endmodule

// ----- rtl/r2q_sqrt.sv -----
// Pipelined digit-by-digit integer square root of rad * 2^16, two bits per stage.
// Uses r2q_pkg.
module r2q_sqrt
    import r2q_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [18:0] rad,
    input  side_t       side_in,
    output logic        out_valid,
    output logic [17:0] root,
    output side_t       side_out
);

    logic        vld_reg  [SQ_STAGES];
    sq_t         st_reg   [SQ_STAGES];
    logic [18:0] rad_reg  [SQ_STAGES];
    side_t       side_reg [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic        v_in;
        sq_t         st_in;
        logic [18:0] rad_in;
        side_t       side_stage_in;
        logic [35:0] v36;
        sq_t         st_next;

        if (k == 0) begin : g_first
            assign v_in          = in_valid;
            assign st_in         = '0;
            assign rad_in        = rad;
            assign side_stage_in = side_in;
        end else begin : g_rest
            assign v_in          = vld_reg[k-1];
            assign st_in         = st_reg[k-1];
            assign rad_in        = rad_reg[k-1];
            assign side_stage_in = side_reg[k-1];
        end

        assign v36     = {1'b0, rad_in, 16'b0};
        assign st_next = sqrt_step(sqrt_step(st_in, v36[35-4*k -: 2]), v36[33-4*k -: 2]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k]   <= st_next;
                rad_reg[k]  <= rad_in;
                side_reg[k] <= side_stage_in;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign root      = st_reg[SQ_STAGES-1].root;
    assign side_out  = side_reg[SQ_STAGES-1];

endmodule

// ----- rtl/r2q_recip.sv -----
// Pipelined restoring divider for s = floor(2^31 / r), three quotient bits per stage.
// Uses r2q_pkg.
module r2q_recip
    import r2q_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [17:0] root_in,
    input  side_t       side_in,
    output logic        out_valid,
    output logic [17:0] root_out,
    output logic [23:0] s_out,
    output side_t       side_out
);

    logic        vld_reg  [DV_STAGES];
    dv_t         dv_reg   [DV_STAGES];
    logic [17:0] root_reg [DV_STAGES];
    side_t       side_reg [DV_STAGES];

    for (genvar k = 0; k < DV_STAGES; k++) begin : g_stage
        logic        v_in;
        dv_t         dv_in;
        logic [17:0] den;
        side_t       side_stage_in;
        dv_t         dv_next;

        if (k == 0) begin : g_first
            assign v_in          = in_valid;
            assign dv_in         = '{rem: 18'(RECIP_REM), quo: '0};
            assign den           = root_in;
            assign side_stage_in = side_in;
        end else begin : g_rest
            assign v_in          = vld_reg[k-1];
            assign dv_in         = dv_reg[k-1];
            assign den           = root_reg[k-1];
            assign side_stage_in = side_reg[k-1];
        end

        assign dv_next = div_step(div_step(div_step(dv_in, den), den), den);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[k]   <= dv_next;
                root_reg[k] <= den;
                side_reg[k] <= side_stage_in;
            end
        end
    end

    assign out_valid = vld_reg[DV_STAGES-1];
    assign root_out  = root_reg[DV_STAGES-1];
    assign s_out     = dv_reg[DV_STAGES-1].quo;
    assign side_out  = side_reg[DV_STAGES-1];

endmodule

// ----- rtl/r2q_post.sv -----
// Scaling multiplies, rounding, component mapping, x-axis flip and saturation.
// Uses r2q_pkg; its second stage is the output register.
module r2q_post
    import r2q_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [17:0]      root,
    input  logic [23:0]      s,
    input  side_t            side_in,
    output logic             valid_reg,
    output logic [OUT_W-1:0] data_reg
);

    logic signed [18:0] d_in [3];
    logic [42:0]        prod_next [3];
    logic [42:0]        prod_reg  [3];
    logic               neg_reg   [3];
    logic               mid_vld_reg;
    logic [1:0]         sel_reg;
    logic [17:0]        half_reg;

    logic [42:0]        rnd [3];
    logic [26:0]        q [3];
    logic signed [28:0] p [3];
    logic signed [28:0] half_s, qw, qx, qy, qz;
    logic [OUT_W-1:0]   data_next;

    always_comb begin
        d_in[0] = side_in.da;
        d_in[1] = side_in.db;
        d_in[2] = side_in.dc;
        // magnitude is taken as unsigned 19 bits so the most negative sum stays 2^18
        for (int i = 0; i < 3; i++)
            prod_next[i] = 43'($unsigned(d_in[i][18] ? 19'(-d_in[i]) : d_in[i])) * 43'(s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_vld_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else if (en) begin
            mid_vld_reg <= in_valid;
            valid_reg   <= mid_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= prod_next[i];
                neg_reg[i]  <= d_in[i][18];
            end
            sel_reg  <= side_in.sel;
            half_reg <= {1'b0, root[17:1]};
            data_reg <= data_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = prod_reg[i] + 43'd32768;
            q[i]   = rnd[i][42:16];
            p[i]   = neg_reg[i] ? -29'(q[i]) : 29'(q[i]);
        end
        half_s = 29'(half_reg);
        qw = (sel_reg == SEL_TRACE) ? half_s : p[0];
        qx = (sel_reg == SEL_TRACE) ? p[0] : (sel_reg == SEL_X) ? half_s : p[1];
        qy = (sel_reg == SEL_TRACE || sel_reg == SEL_X) ? p[1]
           : (sel_reg == SEL_Y) ? half_s : p[2];
        qz = (sel_reg == SEL_Z) ? half_s : p[2];
        data_next = {sat18(-qx), sat18(qy), sat18(-qz), sat18(qw)};
    end

endmodule

// ----- rtl/rotation_to_quaternion_core.sv -----
// Top level: 3x3 rotation matrix (Q1.16) to x-flipped unit quaternion (Q1.16).
// Uses r2q_pkg, r2q_prep, r2q_sqrt, r2q_recip, r2q_post.
//
//   port group   dir  payload (lowest bits first)
//   s_*          in   r00 r01 r02 r10 r11 r12 r20 r21 r22, 18 b signed each, 6 pad
//   m_*          out  quat_w quat_z quat_y quat_x, 18 b signed each
//
// One item per cycle sustained while the output is empty or taken; stages: 1 entry stage,
// 9 square-root stages (2 root bits each), 8 divider stages (3 quotient
// bits each), 1 multiply stage and 1 round/saturate stage that is the
// output register. All stages share one advance enable: the pipe moves
// when the output register is empty or taken, so a stall freezes every
// item in place. Synchronous active-low reset clears all valid bits.
module rotation_to_quaternion_core
    import r2q_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22, 6 zero bits
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // quat_w,quat_z,quat_y,quat_x
);

    logic        en;
    logic        pr_valid;
    logic [18:0] pr_rad;
    side_t       pr_side;
    logic        sq_valid;
    logic [17:0] sq_root;
    side_t       sq_side;
    logic        rc_valid;
    logic [17:0] rc_root;
    logic [23:0] rc_s;
    side_t       rc_side;

    // whole pipe advances unless a finished item waits at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    r2q_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .valid_reg (pr_valid),
        .rad_reg   (pr_rad),
        .side_reg  (pr_side)
    );

    r2q_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pr_valid),
        .rad       (pr_rad),
        .side_in   (pr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    r2q_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .root_in   (sq_root),
        .side_in   (sq_side),
        .out_valid (rc_valid),
        .root_out  (rc_root),
        .s_out     (rc_s),
        .side_out  (rc_side)
    );

    r2q_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rc_valid),
        .root      (rc_root),
        .s         (rc_s),
        .side_in   (rc_side),
        .valid_reg (m_tvalid),
        .data_reg  (m_tdata)
    );

    // radicand is clamped to at least 1 LSB, so the root never drops below 256
    a_root_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_valid |-> sq_root >= 18'd256)
        else $error("square root below clamp floor");

    a_recip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rc_valid |-> (rc_s != 24'd0) && (rc_s <= 24'h800000))
        else $error("reciprocal out of range");

    a_recip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rc_valid |-> (42'(rc_s) * 42'(rc_root)) <= 42'h080000000)
        else $error("reciprocal times root exceeds 2^31");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// ----- test/tb.sv -----
// Testbench for rotation_to_quaternion_core: matrix items in, quaternion items out.
// Depends on r2q_pkg and the core; a scoreboard class predicts and checks each item.

class quat_scoreboard;
    logic [71:0] pending_quats[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    static function logic signed [63:0] round_mul(logic signed [63:0] d, logic signed [63:0] s);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (d < 0) ? -d : d;
        mag = mag * s;
        q = (mag + 64'd32768) >> 16;
        return (d < 0) ? -$signed(q) : $signed(q);
    endfunction

    static function logic [17:0] clip18(logic signed [63:0] v);
        if (v > 131071) return 18'h1FFFF;
        if (v < -131072) return 18'h20000;
        return v[17:0];
    endfunction

    static function logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function void note_matrix(logic [167:0] d);
        logic signed [63:0] m[9];
        logic signed [63:0] t, rad, r, s, half, qx, qy, qz, qw;
        for (int i = 0; i < 9; i++) m[i] = $signed(d[i*18 +: 18]);
        t = m[0] + m[4] + m[8];
        if (t > 0) rad = 65536 + t;
        else if (m[0] > m[4] && m[0] > m[8]) rad = 65536 + m[0] - m[4] - m[8];
        else if (m[4] > m[8]) rad = 65536 + m[4] - m[0] - m[8];
        else rad = 65536 + m[8] - m[0] - m[4];
        if (rad < 1) rad = 1;
        r = int_sqrt(rad << 16);
        half = r >>> 1;
        s = (64'd1 << 31) / r;
        if (t > 0) begin
            qw = half;
            qx = round_mul(m[7] - m[5], s);
            qy = round_mul(m[2] - m[6], s);
            qz = round_mul(m[3] - m[1], s);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            qw = round_mul(m[7] - m[5], s);
            qx = half;
            qy = round_mul(m[1] + m[3], s);
            qz = round_mul(m[6] + m[2], s);
        end else if (m[4] > m[8]) begin
            qw = round_mul(m[2] - m[6], s);
            qx = round_mul(m[1] + m[3], s);
            qy = half;
            qz = round_mul(m[5] + m[7], s);
        end else begin
            qw = round_mul(m[3] - m[1], s);
            qx = round_mul(m[2] + m[6], s);
            qy = round_mul(m[5] + m[7], s);
            qz = half;
        end
        pending_quats.push_back({clip18(-qx), clip18(qy), clip18(-qz), clip18(qw)});
    endfunction

    function void check_quat(logic [71:0] got);
        logic [71:0] exp_q;
        if (pending_quats.size() == 0) begin
            $display("%0t: unexpected item %h", $realtime, got);
            errors++;
            return;
        end
        exp_q = pending_quats.pop_front();
        for (int f = 0; f < 4; f++)
            if (exp_q[f*18 +: 18] !== got[f*18 +: 18]) begin
                $display("%0t: field %0d expected %h actual %h", $realtime, f,
                         exp_q[f*18 +: 18], got[f*18 +: 18]);
                errors++;
            end
    endfunction
endclass

module tb;
    import r2q_pkg::*;

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;

    quat_scoreboard sb = new();
    bit             stim_done = 0;
    int             hold_off = 0;   // long receiver stall, cycles left

    rotation_to_quaternion_core dut (.*);

    always #2 aclk = ~aclk;

    function automatic int gap_len();
        if ($urandom_range(0, 2) != 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [17:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'h10000;
            3: return 18'h30000;
            4: return 18'($urandom_range(0, 2000) - 1000);
            default: return 18'($urandom);
        endcase
    endfunction

    // mostly near-rotation: diagonal in [-1, +1), off-diagonal within +-40000; else random elements
    function automatic logic [167:0] rand_matrix();
        logic [167:0] d;
        int k;
        d = '0;
        k = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++)
            if (k == 0) d[i*18 +: 18] = rand_elem();
            else if (i % 4 == 0) d[i*18 +: 18] = 18'($urandom_range(0, 131071) - 65536);
            else d[i*18 +: 18] = 18'($urandom_range(0, 80000) - 40000);
        return d;
    endfunction

    // valid drops for the whole gap so a held item is never taken twice
    task automatic send_matrix(logic [167:0] d);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_matrix(d);
    endtask

    function automatic logic [167:0] diag(logic [17:0] a, logic [17:0] b, logic [17:0] c,
                                          logic [17:0] o);
        logic [167:0] d;
        for (int i = 0; i < 9; i++) d[i*18 +: 18] = o + 18'(i);
        d[0 +: 18] = a; d[72 +: 18] = b; d[144 +: 18] = c;
        return d;
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_quat(m_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        logic [167:0] d;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // identity, trace branch
        send_matrix(diag(18'h10000, 18'h10000, 18'h10000, 18'd0));
        // each diagonal branch, and ties picking the later branch
        send_matrix(diag(18'h10000, 18'h30000, 18'h30000, 18'd0));
        send_matrix(diag(18'h30000, 18'h10000, 18'h30000, 18'd0));
        send_matrix(diag(18'h30000, 18'h30000, 18'h10000, 18'd0));
        send_matrix(diag(18'h3C000, 18'h3C000, 18'h38000, 18'd0));
        send_matrix(diag(18'h38000, 18'h3C000, 18'h3C000, 18'd0));
        send_matrix(diag(18'd0, 18'd0, 18'd0, 18'd0));
        // full-scale diagonals: trace branch, then z branch with all ties
        send_matrix(diag(18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
        send_matrix(diag(18'h20000, 18'h20000, 18'h20000, 18'h20000));
        // all fields -1 LSB, all zero, then extremes of every element
        send_matrix({168{1'b1}} >> 6);
        send_matrix('0);
        for (int i = 0; i < 9; i++) begin
            d = '0;
            d[i*18 +: 18] = 18'h1FFFF;
            send_matrix(d);
            d[i*18 +: 18] = 18'h20000;
            send_matrix(d);
        end
        // receiver stalls for a long stretch while items keep coming
        hold_off <= 200;
        for (int n = 0; n < 1700; n++) send_matrix(rand_matrix());
        s_tvalid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending_quats.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb: FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/r2q_pkg.sv
rtl/r2q_prep.sv
rtl/r2q_sqrt.sv
rtl/r2q_recip.sv
rtl/r2q_post.sv
rtl/rotation_to_quaternion_core.sv
test/tb.sv
